FILE: src/npcs_pkg.sv
// Package for the nearest palette color search block.
// Holds the command and item types, the back-end state type and field widths.
// Used by every module under src; depends on nothing.
package npcs_pkg;

  localparam int IDX_W       = 8;
  localparam int CH_W        = 8;
  localparam int SQ_W        = 16;
  localparam int DIST_W      = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } q_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

endpackage

FILE: src/npcs_front.sv
// Front end: accepts input transactions, decodes the command and drops loads
// whose index lies beyond the palette. Depends on npcs_pkg.
module npcs_front import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  output logic             push_valid,
  input  logic             push_ready,
  output q_item_t          push_item
);

  logic    fv_r, fv_nxt;
  q_item_t fitem_r;
  logic    keep;
  cmd_t    cmd;

  assign cmd        = cmd_t'(in_op);
  assign keep       = (cmd == CMD_QUERY) ||
                      ({1'b0, in_entry_index} < (IDX_W+1)'(PALETTE_ENTRIES));
  assign in_ready   = !fv_r || push_ready;
  assign push_valid = fv_r;
  assign push_item  = fitem_r;

  always_comb begin
    fv_nxt = fv_r;
    if (fv_r && push_ready) begin
      fv_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      fv_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fitem_r <= '{cmd: cmd, idx: in_entry_index, red: in_red,
                   green: in_green, blue: in_blue};
    end
  end

endmodule

FILE: src/npcs_queue.sv
// Short command queue between the front end and the back end.
// Depends on npcs_pkg for the item type and depth.
module npcs_queue import npcs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_item
);

  q_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/npcs_back.sv
// Back end: palette memory, the pipelined distance scan and the result register.
// Depends on npcs_pkg for the item type, state type and widths.
module npcs_back import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  q_item_t           pop_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_best_index,
  output logic [CH_W-1:0]   out_best_red,
  output logic [CH_W-1:0]   out_best_green,
  output logic [CH_W-1:0]   out_best_blue,
  output logic [DIST_W-1:0] out_best_distance
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

  back_state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          issue, take, do_load, do_query, do_out;

  logic [3*CH_W-1:0] mem_r [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] ent_vld_r;
  logic [CH_W-1:0] qr_r, qg_r, qb_r;

  logic              s1_v_r, rd_vld_r;
  logic [AW-1:0]     s1_idx_r;
  logic [3*CH_W-1:0] rd_data_r;
  logic [3*CH_W-1:0] s1_color;
  logic [CH_W-1:0]   dr, dg, db;

  logic              s2_v_r;
  logic [AW-1:0]     s2_idx_r;
  logic [3*CH_W-1:0] s2_color_r;
  logic [SQ_W-1:0]   sqr_r, sqg_r, sqb_r;

  logic              s3_v_r;
  logic [AW-1:0]     s3_idx_r;
  logic [3*CH_W-1:0] s3_color_r;
  logic [DIST_W-1:0] s3_dist_r;

  logic [AW-1:0]     best_idx_r;
  logic [3*CH_W-1:0] best_color_r;
  logic [DIST_W-1:0] best_dist_r;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [3*CH_W-1:0] out_color_r;
  logic [DIST_W-1:0] out_dist_r;

  assign pop_ready = (state_r == BK_IDLE);
  assign take      = pop_valid && pop_ready;
  assign do_load   = take && (pop_item.cmd == CMD_LOAD);
  assign do_query  = take && (pop_item.cmd == CMD_QUERY);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    issue     = 1'b0;
    do_out    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (do_query) begin
          cnt_nxt   = '0;
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        issue = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = BK_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_DRAIN: begin
        if (!s1_v_r && !s2_v_r && !s3_v_r) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          do_out    = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      mem_r[pop_item.idx[AW-1:0]] <= {pop_item.red, pop_item.green, pop_item.blue};
    end
    rd_data_r <= mem_r[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (do_load) begin
      ent_vld_r[pop_item.idx[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      qr_r <= pop_item.red;
      qg_r <= pop_item.green;
      qb_r <= pop_item.blue;
    end
  end

  // Entries never written since reset read as black.
  assign s1_color = rd_vld_r ? rd_data_r : '0;
  assign dr = (s1_color[3*CH_W-1:2*CH_W] >= qr_r) ?
              s1_color[3*CH_W-1:2*CH_W] - qr_r : qr_r - s1_color[3*CH_W-1:2*CH_W];
  assign dg = (s1_color[2*CH_W-1:CH_W] >= qg_r) ?
              s1_color[2*CH_W-1:CH_W] - qg_r : qg_r - s1_color[2*CH_W-1:CH_W];
  assign db = (s1_color[CH_W-1:0] >= qb_r) ?
              s1_color[CH_W-1:0] - qb_r : qb_r - s1_color[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r   <= ent_vld_r[cnt_r];
    s1_idx_r   <= cnt_r;
    s2_idx_r   <= s1_idx_r;
    s2_color_r <= s1_color;
    sqr_r      <= SQ_W'(dr) * SQ_W'(dr);
    sqg_r      <= SQ_W'(dg) * SQ_W'(dg);
    sqb_r      <= SQ_W'(db) * SQ_W'(db);
    s3_idx_r   <= s2_idx_r;
    s3_color_r <= s2_color_r;
    s3_dist_r  <= DIST_W'(sqr_r) + DIST_W'(sqg_r) + DIST_W'(sqb_r);
  end

  // A later entry replaces the best only on a strictly smaller distance.
  always_ff @(posedge clk) begin
    if (s3_v_r && ((s3_idx_r == '0) || (s3_dist_r < best_dist_r))) begin
      best_idx_r   <= s3_idx_r;
      best_color_r <= s3_color_r;
      best_dist_r  <= s3_dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      out_idx_r   <= IDX_W'(best_idx_r);
      out_color_r <= best_color_r;
      out_dist_r  <= best_dist_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_index    = out_idx_r;
  assign out_best_red      = out_color_r[3*CH_W-1:2*CH_W];
  assign out_best_green    = out_color_r[2*CH_W-1:CH_W];
  assign out_best_blue     = out_color_r[CH_W-1:0];
  assign out_best_distance = out_dist_r;

endmodule

FILE: src/nearest_palette_color_search_top.sv
// Top level of the nearest palette color search block.
// Instantiates npcs_front, npcs_queue and npcs_back; depends on npcs_pkg.
//
// The input channel carries load and query transactions. A load (op 0) writes
// one palette entry and returns nothing; a load whose index is not below
// PALETTE_ENTRIES is dropped. A query (op 1) returns one result transaction:
// the index of the nearest entry by squared RGB distance, lowest index on a
// tie, with that entry's color and the distance.
// A front register decodes each transaction and passes it through a four-deep
// queue to the back end, which executes commands in order. A query scans the
// palette one entry per cycle through a four-stage read, square, sum and
// compare pipeline and occupies the back end until its result enters the
// output register. That scan sets the throughput.
// After reset every palette entry reads as black and no result is pending.
// If the receiver stalls, the result waits in the output register; loads keep
// executing, and a following query scans but holds its result until the
// register is free. Input is refused only when the queue and front are full.
module nearest_palette_color_search_top import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [CH_W-1:0]   in_red,
  input  logic [CH_W-1:0]   in_green,
  input  logic [CH_W-1:0]   in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_best_index,
  output logic [CH_W-1:0]   out_best_red,
  output logic [CH_W-1:0]   out_best_green,
  output logic [CH_W-1:0]   out_best_blue,
  output logic [DIST_W-1:0] out_best_distance
);

  logic    push_valid, push_ready, pop_valid, pop_ready;
  q_item_t push_item, pop_item;

  npcs_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  npcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  npcs_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_item          (pop_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_best_index    (out_best_index),
    .out_best_red      (out_best_red),
    .out_best_green    (out_best_green),
    .out_best_blue     (out_best_blue),
    .out_best_distance (out_best_distance)
  );

endmodule
